// ----- src/wsfp_pkg.sv -----
`default_nettype none
package wsfp_pkg;

  localparam int unsigned LEN_W = 24;

  localparam logic [3:0] OP_CLOSE = 4'h8;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 24'd1048576;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_CLOSE = 2'd1;
  localparam logic [1:0] EV_LEN   = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] frame_opcode;
    logic       has_byte;
    logic       frame_end;
    logic [1:0] event_res;
  } res_t;

endpackage
`default_nettype wire

// ----- src/wsfp_core.sv -----
`default_nettype none
module wsfp_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         accept,
  input  wire logic [7:0]                   rx_byte,
  input  wire logic [wsfp_pkg::LEN_W-1:0]   max_payload,
  output logic                              res_valid,
  output wsfp_pkg::res_t                    res
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD,
    PH_STOPPED
  } phase_t;

  phase_t                      phase, phase_next;
  logic [3:0]                  cur_opcode, cur_opcode_next;
  logic                        mask_on, mask_on_next;
  logic [3:0]                  ext_len_left, ext_len_left_next;
  logic [wsfp_pkg::LEN_W-1:0]  len_low, len_low_next;
  logic                        len_hi, len_hi_next;
  logic [wsfp_pkg::LEN_W-1:0]  payload_left, payload_left_next;
  logic [31:0]                 mask_key, mask_key_next;
  logic [1:0]                  key_index, key_index_next;

  logic                        do_len;
  logic                        do_begin;
  logic [wsfp_pkg::LEN_W-1:0]  chk_low;
  logic                        chk_hi;
  logic [wsfp_pkg::LEN_W-1:0]  bp_left;
  logic [7:0]                  kb;
  logic [wsfp_pkg::LEN_W-1:0]  left_dec;

  always_comb begin
    phase_next        = phase;
    cur_opcode_next   = cur_opcode;
    mask_on_next      = mask_on;
    ext_len_left_next = ext_len_left;
    len_low_next      = len_low;
    len_hi_next       = len_hi;
    payload_left_next = payload_left;
    mask_key_next     = mask_key;
    key_index_next    = key_index;
    do_len            = 1'b0;
    do_begin          = 1'b0;
    chk_low           = len_low;
    chk_hi            = len_hi;
    bp_left           = payload_left;
    kb                = 8'd0;
    left_dec          = payload_left - 1'b1;
    res_valid         = 1'b0;
    res.out_byte      = 8'd0;
    res.frame_opcode  = cur_opcode;
    res.has_byte      = 1'b0;
    res.frame_end     = 1'b0;
    res.event_res     = wsfp_pkg::EV_NONE;

    unique case (phase)
      PH_HDR0: begin
        cur_opcode_next = rx_byte[3:0];
        phase_next      = PH_HDR1;
      end
      PH_HDR1: begin
        mask_on_next = rx_byte[7];
        len_hi_next  = 1'b0;
        len_low_next = '0;
        if (rx_byte[6:0] == wsfp_pkg::LEN7_EXT16) begin
          ext_len_left_next = wsfp_pkg::EXT16_BYTES;
          phase_next        = PH_EXTLEN;
        end else if (rx_byte[6:0] == wsfp_pkg::LEN7_EXT64) begin
          ext_len_left_next = wsfp_pkg::EXT64_BYTES;
          phase_next        = PH_EXTLEN;
        end else begin
          chk_low = {{(wsfp_pkg::LEN_W-7){1'b0}}, rx_byte[6:0]};
          chk_hi  = 1'b0;
          do_len  = 1'b1;
        end
      end
      PH_EXTLEN: begin
        len_hi_next       = len_hi | (|len_low[wsfp_pkg::LEN_W-1:wsfp_pkg::LEN_W-8]);
        len_low_next      = {len_low[wsfp_pkg::LEN_W-9:0], rx_byte};
        ext_len_left_next = ext_len_left - 4'd1;
        chk_low           = len_low_next;
        chk_hi            = len_hi_next;
        do_len            = (ext_len_left == 4'd1);
      end
      PH_MASK: begin
        mask_key_next = {mask_key[23:0], rx_byte};
        if (key_index == 2'd3) begin
          do_begin = 1'b1;
        end else begin
          key_index_next = key_index + 2'd1;
        end
      end
      PH_PAYLOAD: begin
        if (mask_on) begin
          unique case (key_index)
            2'd0: kb = mask_key[31:24];
            2'd1: kb = mask_key[23:16];
            2'd2: kb = mask_key[15:8];
            2'd3: kb = mask_key[7:0];
            default: kb = 8'd0;
          endcase
        end
        key_index_next    = key_index + 2'd1;
        payload_left_next = left_dec;
        res_valid         = 1'b1;
        res.out_byte      = rx_byte ^ kb;
        res.has_byte      = 1'b1;
        if (left_dec == '0) begin
          res.frame_end = 1'b1;
          if (cur_opcode == wsfp_pkg::OP_CLOSE) begin
            res.event_res = wsfp_pkg::EV_CLOSE;
            phase_next    = PH_STOPPED;
          end else begin
            phase_next = PH_HDR0;
          end
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase

    // length check, then mask key or payload start
    if (do_len) begin
      if (chk_hi || (chk_low > max_payload)) begin
        phase_next    = PH_STOPPED;
        res_valid     = 1'b1;
        res.event_res = wsfp_pkg::EV_LEN;
      end else begin
        payload_left_next = chk_low;
        bp_left           = chk_low;
        if (mask_on_next) begin
          mask_key_next  = '0;
          key_index_next = 2'd0;
          phase_next     = PH_MASK;
        end else begin
          do_begin = 1'b1;
        end
      end
    end

    if (do_begin) begin
      key_index_next = 2'd0;
      if (bp_left == '0) begin
        res_valid     = 1'b1;
        res.frame_end = 1'b1;
        if (cur_opcode == wsfp_pkg::OP_CLOSE) begin
          res.event_res = wsfp_pkg::EV_CLOSE;
          phase_next    = PH_STOPPED;
        end else begin
          phase_next = PH_HDR0;
        end
      end else begin
        phase_next = PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      cur_opcode   <= '0;
      mask_on      <= 1'b0;
      ext_len_left <= '0;
      len_low      <= '0;
      len_hi       <= 1'b0;
      payload_left <= '0;
      mask_key     <= '0;
      key_index    <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      cur_opcode   <= cur_opcode_next;
      mask_on      <= mask_on_next;
      ext_len_left <= ext_len_left_next;
      len_low      <= len_low_next;
      len_hi       <= len_hi_next;
      payload_left <= payload_left_next;
      mask_key     <= mask_key_next;
      key_index    <= key_index_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/websocket_frame_parser_unit.sv -----
// websocket frame parser: takes the received stream one byte per transfer
// on the input channel (in_valid / in_stall, rx_byte) and gives at most one
// result per byte on the output channel (out_valid / out_stall): an unmasked
// payload byte with the frame opcode, an empty-frame marker, or an event.
// header, extended length and mask key bytes give no result, but the byte
// that ends a header may give an empty-frame marker or a length error.
// throughput: one byte per cycle while in_stall is low, set by the
// combinational header and unmask update of the parser state registers.
// a result that waits under out_stall stays in the output register; one more
// result goes to a skid register, and in_stall rises only while that skid
// register is full, so bytes that give no result still flow meanwhile.
// cfg_wr_en / cfg_wr_data write max_payload; write it only while idle.
// after a close frame completes or a length error, the parser drops every
// byte without result until reset.
// rst (synchronous) empties both registers, returns the parser to the first
// header byte and sets max_payload to 1048576.
`default_nettype none
module websocket_frame_parser_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  rx_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [7:0]                       out_byte,
  output logic [3:0]                       frame_opcode,
  output logic                             has_byte,
  output logic                             frame_end,
  output logic [1:0]                       event_res,
  input  wire logic                        cfg_wr_en,
  input  wire logic [wsfp_pkg::LEN_W-1:0]  cfg_wr_data
);

  logic [wsfp_pkg::LEN_W-1:0] max_payload;
  logic                       in_take;
  logic                       out_take;
  logic                       res_valid;
  wsfp_pkg::res_t             res;
  wsfp_pkg::res_t             out_reg;
  wsfp_pkg::res_t             skid_reg;
  logic                       skid_valid;

  assign in_stall = skid_valid;
  assign in_take  = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  wsfp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_take),
    .rx_byte     (rx_byte),
    .max_payload (max_payload),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= wsfp_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_wr_en) begin
      max_payload <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take || !out_valid) begin
          out_reg    <= skid_reg;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (in_take && res_valid) begin
        if (out_take || !out_valid) begin
          out_reg   <= res;
          out_valid <= 1'b1;
        end else begin
          skid_reg   <= res;
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_byte     = out_reg.out_byte;
  assign frame_opcode = out_reg.frame_opcode;
  assign has_byte     = out_reg.has_byte;
  assign frame_end    = out_reg.frame_end;
  assign event_res    = out_reg.event_res;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  a_skid_after_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid register filled without a stalled output");

  a_empty_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_byte) |-> (out_byte == 8'd0))
    else $error("nonzero byte on a result without data");

  a_len_err_no_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == wsfp_pkg::EV_LEN) |-> (!frame_end && !has_byte))
    else $error("length error result marked as frame data");

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [3:0] OP_PING = 4'h9;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXTLEN, PH_MASK, PH_PAYLOAD, PH_STOPPED
  } parse_phase_t;

  typedef enum logic [1:0] {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

  class frame_tracker;
    parse_phase_t phase;
    logic [3:0] opcode;
    logic mask_on;
    logic [3:0] ext_left;
    logic [63:0] frame_len;
    logic [24:0] payload_left;
    logic [31:0] mask_key;
    logic [1:0] key_idx;
    logic [wsfp_pkg::LEN_W-1:0] max_len;
    wsfp_pkg::res_t parsed_results[$];
    int unsigned errors;
    int unsigned matched;

    function new();
      errors = 0;
      matched = 0;
      clear();
    endfunction

    function void clear();
      phase = PH_HDR0;
      opcode = '0;
      mask_on = 1'b0;
      ext_left = '0;
      frame_len = '0;
      payload_left = '0;
      mask_key = '0;
      key_idx = '0;
      max_len = wsfp_pkg::MAX_PAYLOAD_RESET;
      parsed_results.delete();
    endfunction

    function void push(logic [7:0] b, logic has, logic fin, logic [1:0] ev);
      wsfp_pkg::res_t r;
      r.out_byte = b;
      r.frame_opcode = opcode;
      r.has_byte = has;
      r.frame_end = fin;
      r.event_res = ev;
      parsed_results = {parsed_results, r};
    endfunction

    function void start_payload();
      key_idx = '0;
      if (payload_left == 0) begin
        push(8'h00, 1'b0, 1'b1,
             (opcode == wsfp_pkg::OP_CLOSE) ? wsfp_pkg::EV_CLOSE : wsfp_pkg::EV_NONE);
        phase = (opcode == wsfp_pkg::OP_CLOSE) ? PH_STOPPED : PH_HDR0;
      end else begin
        phase = PH_PAYLOAD;
      end
    endfunction

    function void length_known();
      if (frame_len > {40'b0, max_len}) begin
        phase = PH_STOPPED;
        push(8'h00, 1'b0, 1'b0, wsfp_pkg::EV_LEN);
      end else begin
        payload_left = frame_len[24:0];
        if (mask_on) begin
          mask_key = '0;
          key_idx = '0;
          phase = PH_MASK;
        end else begin
          start_payload();
        end
      end
    endfunction

    function void parse_byte(logic [7:0] b);
      logic [7:0] kb;
      case (phase)
        PH_HDR0: begin
          opcode = b[3:0];
          phase = PH_HDR1;
        end
        PH_HDR1: begin
          mask_on = b[7];
          frame_len = '0;
          if (b[6:0] == wsfp_pkg::LEN7_EXT16) begin
            ext_left = wsfp_pkg::EXT16_BYTES;
            phase = PH_EXTLEN;
          end else if (b[6:0] == wsfp_pkg::LEN7_EXT64) begin
            ext_left = wsfp_pkg::EXT64_BYTES;
            phase = PH_EXTLEN;
          end else begin
            frame_len = {57'b0, b[6:0]};
            length_known();
          end
        end
        PH_EXTLEN: begin
          frame_len = {frame_len[55:0], b};
          ext_left = ext_left - 4'd1;
          if (ext_left == 0) length_known();
        end
        PH_MASK: begin
          mask_key = {mask_key[23:0], b};
          if (key_idx == 2'd3) start_payload();
          else key_idx = key_idx + 2'd1;
        end
        PH_PAYLOAD: begin
          kb = mask_on ? 8'(mask_key >> (24 - 8 * key_idx)) : 8'h00;
          key_idx = key_idx + 2'd1;
          payload_left = payload_left - 25'd1;
          if (payload_left == 0) begin
            push(b ^ kb, 1'b1, 1'b1,
                 (opcode == wsfp_pkg::OP_CLOSE) ? wsfp_pkg::EV_CLOSE : wsfp_pkg::EV_NONE);
            phase = (opcode == wsfp_pkg::OP_CLOSE) ? PH_STOPPED : PH_HDR0;
          end else begin
            push(b ^ kb, 1'b1, 1'b0, wsfp_pkg::EV_NONE);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task match_result(wsfp_pkg::res_t got);
      wsfp_pkg::res_t want;
      string bad;
      if (parsed_results.size() == 0) begin
        report($sformatf("result %p with nothing pending", got));
        return;
      end
      want = parsed_results.pop_front();
      bad = "";
      if (got.out_byte !== want.out_byte) bad = {bad, " out_byte"};
      if (got.frame_opcode !== want.frame_opcode) bad = {bad, " frame_opcode"};
      if (got.has_byte !== want.has_byte) bad = {bad, " has_byte"};
      if (got.frame_end !== want.frame_end) bad = {bad, " frame_end"};
      if (got.event_res !== want.event_res) bad = {bad, " event_res"};
      if (bad != "") report($sformatf("field(s)%s: got %p want %p", bad, got, want));
      else matched++;
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [7:0] rx_byte;
  logic out_valid;
  logic out_stall;
  logic [7:0] out_byte;
  logic [3:0] frame_opcode;
  logic has_byte;
  logic frame_end;
  logic [1:0] event_res;
  logic cfg_wr_en;
  logic [wsfp_pkg::LEN_W-1:0] cfg_wr_data;

  frame_tracker sb;
  wsfp_pkg::res_t seen;
  bit idle_on;
  bit valid_up;
  logic [wsfp_pkg::LEN_W-1:0] max_cfg;
  int unsigned bytes_sent;
  int unsigned frames_sent;
  int unsigned byte_xfers;
  int unsigned cfg_writes;
  int unsigned cycles;
  int unsigned stall_left;
  bit ended_by_close;

  websocket_frame_parser_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .frame_opcode(frame_opcode),
    .has_byte(has_byte),
    .frame_end(frame_end),
    .event_res(event_res),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // transfer monitor
  always @(posedge clk) begin
    if (rst) begin
      sb.clear();
    end else begin
      if (cfg_wr_en) sb.max_len = cfg_wr_data;
      if (in_valid && !in_stall) begin
        sb.parse_byte(rx_byte);
        byte_xfers++;
      end
      if (out_valid && !out_stall) begin
        seen.out_byte = out_byte;
        seen.frame_opcode = frame_opcode;
        seen.has_byte = has_byte;
        seen.frame_end = frame_end;
        seen.event_res = event_res;
        sb.match_result(seen);
      end
    end
  end

  function automatic int unsigned pick_len();
    if ($urandom_range(0, 99) < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output back-pressure
  initial begin
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!idle_on) begin
        stall_left = 0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < 25) begin
        stall_left = pick_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 1)) ? pick_len() : 0;
    if (gap > 0) begin
      if (valid_up) begin
        in_valid <= 1'b0;
        valid_up = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    valid_up = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic drain();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    while (sb.parsed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max(input logic [wsfp_pkg::LEN_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_cfg = v;
    cfg_writes++;
  endtask

  task automatic send_frame(input logic [7:0] hdr0, input logic masked, input logic [63:0] len,
                            input len_form_t form, input logic [31:0] key);
    send_byte(hdr0);
    case (form)
      LEN_SHORT: send_byte({masked, len[6:0]});
      LEN_EXT16: begin
        send_byte({masked, wsfp_pkg::LEN7_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, wsfp_pkg::LEN7_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    frames_sent++;
    if (len > {40'b0, max_cfg}) return;
    if (masked) for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    for (longint unsigned i = 0; i < len; i++) send_byte(8'($urandom));
  endtask

  task automatic rand_frame();
    logic [3:0] op;
    logic [63:0] len;
    len_form_t form;
    int unsigned r;
    op = 4'($urandom_range(0, 15));
    if (op == wsfp_pkg::OP_CLOSE) op = OP_PING;
    r = $urandom_range(0, 99);
    if (r < 15) len = '0;
    else if (r < 70) len = 64'($urandom_range(1, 12));
    else if (r < 88) len = 64'($urandom_range(13, 125));
    else len = 64'($urandom_range(126, 300));
    if ($urandom_range(0, 9) == 0 && max_cfg <= 300) len = {40'b0, max_cfg};
    if (len > {40'b0, max_cfg}) len = {40'b0, max_cfg};
    if (len > 125) form = ($urandom_range(0, 3) == 0) ? LEN_EXT64 : LEN_EXT16;
    else if ($urandom_range(0, 9) == 0) form = $urandom_range(0, 1) ? LEN_EXT64 : LEN_EXT16;
    else form = LEN_SHORT;
    send_frame({4'($urandom_range(0, 15)), op}, 1'($urandom_range(0, 1)), len, form,
               $urandom);
  endtask

  initial begin
    logic [63:0] bad_len;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    sb = new();
    idle_on = 1'b0;
    valid_up = 1'b0;
    max_cfg = wsfp_pkg::MAX_PAYLOAD_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // short text, masked binary, empty ping, 16- and 64-bit length forms
    send_frame(8'h81, 1'b0, 64'd1, LEN_SHORT, 32'h0);
    send_frame(8'h02, 1'b1, 64'd4, LEN_SHORT, 32'h0180FF5A);
    send_frame(8'h89, 1'b0, 64'd0, LEN_SHORT, 32'h0);
    send_frame(8'hF2, 1'b0, 64'd1, LEN_EXT16, 32'h0);
    send_frame(8'h7F, 1'b0, 64'd0, LEN_EXT64, 32'h0);
    drain();

    write_max(24'hFFFFFF);
    idle_on = 1'b1;
    while (bytes_sent < 200) rand_frame();
    idle_on = 1'b0;
    while (bytes_sent < 320) rand_frame();
    drain();

    // zero limit: only empty frames pass
    write_max(24'd0);
    idle_on = 1'b1;
    while (bytes_sent < 400) rand_frame();
    drain();

    write_max(24'($urandom_range(1, 40)));
    while (bytes_sent < 600) rand_frame();
    drain();

    write_max(24'($urandom_range(126, 400)));
    while (bytes_sent < 850) rand_frame();
    drain();

    // stopping frame, then bytes that must be dropped
    ended_by_close = 1'($urandom_range(0, 1));
    if (ended_by_close) begin
      send_frame({4'($urandom_range(0, 15)), wsfp_pkg::OP_CLOSE}, 1'($urandom_range(0, 1)),
                 64'($urandom_range(0, 5)), LEN_SHORT, $urandom);
    end else begin
      bad_len = $urandom_range(0, 1) ? 64'(max_cfg) + 64'd1
                                     : {1'b1, 31'($urandom), 32'($urandom)};
      send_frame(8'($urandom), 1'($urandom_range(0, 1)), bad_len,
                 (bad_len <= 64'd65535) ? LEN_EXT16 : LEN_EXT64, $urandom);
    end
    repeat (8) send_byte(8'($urandom));
    drain();

    if (sb.parsed_results.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.parsed_results.size()));
    $display("covered %0d byte transfers in %0d frames, %0d results matched, %0d limit writes",
             byte_xfers, frames_sent, sb.matched, cfg_writes);
    $display("run stopped by %s", ended_by_close ? "a close frame" : "a length error");
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/wsfp_pkg.sv
src/wsfp_core.sv
src/websocket_frame_parser_unit.sv
dv/tb_top.sv
